### design/imu_fsl_pkg.sv
// shared types and constants for the imu frame-status line parser
// no dependencies; imported by every module of the block
package imu_fsl_pkg;

  // width of one result field on the ports
  localparam int DATA_W   = 32;
  localparam int N_FIELDS = 8;

  // ascii codes the parser reacts to
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  // record kinds on the result channel
  typedef enum logic [2:0] {
    KIND_IMU    = 3'd0,
    KIND_EOF    = 3'd1,
    KIND_SKIP   = 3'd2,
    KIND_WD_RST = 3'd3,
    KIND_WD_ERR = 3'd4
  } kind_t;

  // one byte handed from the input register to the parser
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } byte_req_t;

  // a closed line handed from the parser to the output stage
  typedef struct packed {
    logic                               vld;
    logic [7:0]                         rtype;
    logic [N_FIELDS-1:0][DATA_W-1:0]    field;
  } line_t;

endpackage

### design/imu_fsl_in.sv
// input register stage of the imu frame-status line parser
// depends on imu_fsl_pkg; holds one byte and hands it on to the parser
module imu_fsl_in
  import imu_fsl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  input  logic       out_block,
  output byte_req_t  req
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       go;
  logic       take;

  // a newline waits while the result register is full and stalled
  assign go       = vld_r && !((byte_r == CH_NL) && out_block);
  assign in_stall = vld_r && !go;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (go) begin
      vld_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // byte payload
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_rx_byte;
    end
  end

  assign req.vld  = go;
  assign req.data = byte_r;

endmodule

### design/imu_fsl_parse.sv
// line parser of the imu frame-status line parser: sync, type, colon, eight numbers
// depends on imu_fsl_pkg; consumes bytes from imu_fsl_in, feeds imu_fsl_out
module imu_fsl_parse
  import imu_fsl_pkg::*;
#(
  parameter int FIELD_BITS = 32
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  byte_req_t req,
  output line_t     line
);

  localparam int AW = FIELD_BITS + 1;
  localparam int PW = FIELD_BITS + 4;

  localparam logic [3:0] POS_TYPE  = 4'd0;
  localparam logic [3:0] POS_COLON = 4'd1;
  localparam logic [3:0] POS_FIRST = 4'd2;
  localparam logic [3:0] POS_LAST  = 4'd9;
  localparam logic [3:0] POS_DONE  = 4'd10;

  localparam logic [PW-1:0]         CAP_P  = PW'(1) << FIELD_BITS;
  localparam logic [FIELD_BITS-1:0] UMAX   = '1;
  localparam logic [AW-1:0]         HALF_A = AW'(1) << (FIELD_BITS - 1);
  localparam logic [AW-1:0]         HMAX_A = HALF_A - AW'(1);

  logic                            synced_r, synced_nxt;
  logic [3:0]                      pos_r, pos_nxt;
  logic                            failed_r, failed_nxt;
  logic [AW-1:0]                   acc_r, acc_nxt;
  logic                            neg_r, neg_nxt;
  logic                            dseen_r, dseen_nxt;
  logic                            sseen_r, sseen_nxt;
  logic [7:0]                      rtype_r, rtype_nxt;
  logic [N_FIELDS-1:0][DATA_W-1:0] fld_r, fld_nxt, fld_out;

  logic [7:0]            c;
  logic                  is_digit, is_space, is_sign, is_minus, is_nul;
  logic [PW-1:0]         acc_ext, prod, prod_sat;
  logic [2:0]            idx;
  logic [FIELD_BITS-1:0] u_sat, u_val;
  logic [AW-1:0]         s_sat;
  logic [DATA_W-1:0]     s32, s_val, cval;
  logic                  commit, clr, line_vld, in_num;

  // byte classes
  assign c        = req.data;
  assign is_digit = (c >= CH_0) && (c <= CH_9);
  assign is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
                    (c == CH_VT) || (c == CH_FF);
  assign is_minus = (c == CH_MINUS);
  assign is_sign  = (c == CH_PLUS) || is_minus;
  assign is_nul   = (c == CH_NUL);
  assign in_num   = (pos_r >= POS_FIRST) && (pos_r < POS_DONE);

  // times ten plus digit, capped at 2^FIELD_BITS
  assign acc_ext  = PW'(acc_r);
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + PW'(c - CH_0);
  assign prod_sat = (prod > CAP_P) ? CAP_P : prod;

  // saturate and sign the pending number for its slot
  assign idx = 3'(pos_r - POS_FIRST);
  always_comb begin
    u_sat = acc_r[FIELD_BITS] ? UMAX : acc_r[FIELD_BITS-1:0];
    u_val = neg_r ? -u_sat : u_sat;
    if (neg_r) begin
      s_sat = (acc_r > HALF_A) ? HALF_A : acc_r;
    end else begin
      s_sat = (acc_r > HMAX_A) ? HMAX_A : acc_r;
    end
    s32   = DATA_W'(s_sat[FIELD_BITS-1:0]);
    s_val = neg_r ? -s32 : s32;
    cval  = (idx < 3'd2) ? DATA_W'(u_val) : s_val;
  end

  // per-byte parse step
  always_comb begin
    synced_nxt = synced_r;
    pos_nxt    = pos_r;
    failed_nxt = failed_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    dseen_nxt  = dseen_r;
    sseen_nxt  = sseen_r;
    rtype_nxt  = rtype_r;
    fld_nxt    = fld_r;
    fld_out    = fld_r;
    commit     = 1'b0;
    clr        = 1'b0;
    line_vld   = 1'b0;
    if (req.vld) begin
      if (!synced_r) begin
        if (c == CH_NL) begin
          synced_nxt = 1'b1;
          clr        = 1'b1;
        end
      end else if (c != CH_NL) begin
        if (!failed_r) begin
          if (pos_r == POS_TYPE) begin
            if (is_nul) begin
              failed_nxt = 1'b1;
            end else begin
              rtype_nxt = c;
              pos_nxt   = POS_COLON;
            end
          end else if (pos_r == POS_COLON) begin
            if (c == CH_COLON) begin
              pos_nxt = POS_FIRST;
            end else begin
              failed_nxt = 1'b1;
            end
          end else if (pos_r != POS_DONE) begin
            if (is_digit) begin
              acc_nxt   = prod_sat[AW-1:0];
              dseen_nxt = 1'b1;
            end else if (!dseen_r && !sseen_r && is_space) begin
              acc_nxt = acc_r;
            end else if (!dseen_r && !sseen_r && is_sign) begin
              sseen_nxt = 1'b1;
              neg_nxt   = is_minus;
            end else if (dseen_r) begin
              // digit run ends: store it, this byte may open the next number
              commit    = 1'b1;
              pos_nxt   = pos_r + 4'd1;
              acc_nxt   = '0;
              neg_nxt   = 1'b0;
              dseen_nxt = 1'b0;
              sseen_nxt = 1'b0;
              if (is_nul) begin
                failed_nxt = 1'b1;
              end else if (!is_space && (pos_r != POS_LAST)) begin
                if (is_sign) begin
                  sseen_nxt = 1'b1;
                  neg_nxt   = is_minus;
                end else begin
                  failed_nxt = 1'b1;
                end
              end
            end else begin
              failed_nxt = 1'b1;
            end
          end
        end
      end else begin
        // newline closes the line, flushing a pending digit run
        line_vld = 1'b1;
        if (!failed_r && dseen_r && in_num) begin
          fld_out[idx] = cval;
        end
        clr = 1'b1;
      end
    end
    if (commit) begin
      fld_nxt[idx] = cval;
    end
    if (clr) begin
      pos_nxt    = POS_TYPE;
      failed_nxt = 1'b0;
      acc_nxt    = '0;
      neg_nxt    = 1'b0;
      dseen_nxt  = 1'b0;
      sseen_nxt  = 1'b0;
      rtype_nxt  = '0;
      fld_nxt    = '0;
    end
  end

  // parse control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      synced_r <= 1'b0;
      pos_r    <= POS_TYPE;
      failed_r <= 1'b0;
      acc_r    <= '0;
      neg_r    <= 1'b0;
      dseen_r  <= 1'b0;
      sseen_r  <= 1'b0;
      rtype_r  <= '0;
    end else begin
      synced_r <= synced_nxt;
      pos_r    <= pos_nxt;
      failed_r <= failed_nxt;
      acc_r    <= acc_nxt;
      neg_r    <= neg_nxt;
      dseen_r  <= dseen_nxt;
      sseen_r  <= sseen_nxt;
      rtype_r  <= rtype_nxt;
    end
  end

  // captured numbers, cleared by the sync newline before first use
  always_ff @(posedge clk) begin
    fld_r <= fld_nxt;
  end

  assign line.vld   = line_vld;
  assign line.rtype = rtype_r;
  assign line.field = fld_out;

`ifndef SYNTHESIS
  a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_DONE)
    else $error("parse position out of range");

  a_digit_pos : assert property (@(posedge clk) disable iff (!rst_n)
    dseen_r |-> (pos_r >= POS_FIRST) && (pos_r < POS_DONE))
    else $error("digit run outside the number slots");

  a_line_clear : assert property (@(posedge clk) disable iff (!rst_n)
    line_vld |=> (pos_r == POS_TYPE) && !failed_r && !dseen_r && (rtype_r == 8'h00))
    else $error("line state not cleared after newline");
`endif

endmodule

### design/imu_fsl_out.sv
// result stage of the imu frame-status line parser: record kind, watchdog, result register
// depends on imu_fsl_pkg; takes closed lines from imu_fsl_parse
module imu_fsl_out
  import imu_fsl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  line_t                    line,
  output logic                     out_block,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_record_kind,
  output logic [DATA_W-1:0]        out_stamp_nsec,
  output logic [DATA_W-1:0]        out_stamp_sec,
  output logic signed [DATA_W-1:0] out_accel_x,
  output logic signed [DATA_W-1:0] out_accel_y,
  output logic signed [DATA_W-1:0] out_accel_z,
  output logic signed [DATA_W-1:0] out_gyro_x,
  output logic signed [DATA_W-1:0] out_gyro_y,
  output logic signed [DATA_W-1:0] out_gyro_z
);

  logic                            vld_r, vld_nxt;
  logic [1:0]                      wd_r, wd_nxt;
  kind_t                           kind_r, kind_nxt;
  logic [N_FIELDS-1:0][DATA_W-1:0] fld_r, fld_nxt;
  logic                            emit;

  // record kind and watchdog count from the line type
  always_comb begin
    emit     = 1'b0;
    kind_nxt = kind_r;
    wd_nxt   = wd_r;
    fld_nxt  = line.field;
    case (line.rtype)
      CH_I: begin
        emit     = 1'b1;
        kind_nxt = KIND_IMU;
      end
      CH_E: begin
        emit     = 1'b1;
        kind_nxt = KIND_EOF;
        wd_nxt   = 2'd0;
      end
      CH_S: begin
        emit     = 1'b1;
        kind_nxt = KIND_SKIP;
      end
      CH_W: begin
        emit     = 1'b1;
        wd_nxt   = (wd_r == 2'd3) ? 2'd3 : wd_r + 2'd1;
        kind_nxt = (wd_nxt > 2'd1) ? KIND_WD_ERR : KIND_WD_RST;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    emit = emit && line.vld;
    if (!emit) begin
      wd_nxt = wd_r;
    end
    // only imu records carry the motion fields
    if (kind_nxt != KIND_IMU) begin
      for (int k = 2; k < N_FIELDS; k++) begin
        fld_nxt[k] = '0;
      end
    end
  end

  // result valid
  always_comb begin
    vld_nxt = vld_r;
    if (emit) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      wd_r  <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      wd_r  <= wd_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= kind_nxt;
      fld_r  <= fld_nxt;
    end
  end

  assign out_block       = vld_r && out_stall;
  assign out_valid       = vld_r;
  assign out_record_kind = kind_r;
  assign out_stamp_nsec  = fld_r[0];
  assign out_stamp_sec   = fld_r[1];
  assign out_accel_x     = fld_r[2];
  assign out_accel_y     = fld_r[3];
  assign out_accel_z     = fld_r[4];
  assign out_gyro_x      = fld_r[5];
  assign out_gyro_y      = fld_r[6];
  assign out_gyro_z      = fld_r[7];

`ifndef SYNTHESIS
  a_wd_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && (kind_r == KIND_WD_RST)) |-> (wd_r == 2'd1))
    else $error("watchdog restart shown with count other than one");

  a_wd_error : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && (kind_r == KIND_WD_ERR)) |-> (wd_r >= 2'd2))
    else $error("watchdog error shown with count below two");

  a_no_motion : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && (kind_r != KIND_IMU)) |-> ((fld_r[2] == '0) && (fld_r[7] == '0)))
    else $error("motion fields set on a non-imu record");
`endif

endmodule

### design/imu_frame_status_line_parser.sv
// Top level of the imu frame-status line parser.
// Depends on imu_fsl_pkg, imu_fsl_in, imu_fsl_parse and imu_fsl_out.
//
// Input channel: one serial byte per request on in_rx_byte, taken when in_valid
// is high and in_stall is low. Bytes are dropped up to and including the
// first newline; after that every newline closes a text line "T:n s a b c d e f".
// Result channel: one record per closed line of type I, E, S or W, shown on
// out_valid and taken when out_stall is low. Other line types give nothing.
// A newline taken into the input register passes through the parse logic into
// the result register, which shows its record on out_valid.
// Throughput: one byte per cycle unless a newline waits; the digit accumulate is
// a shift-add by ten and a compare with 2^FIELD_BITS between the two registers.
// When the receiver stalls with a record waiting, ordinary bytes keep flowing;
// only a newline is held in the input register (and in_stall rises) until the
// waiting record is taken.
// Reset (rst_n low at a clock edge) drops any held byte and record, clears the
// watchdog count and returns the parser to its wait-for-first-newline state.
// FIELD_BITS (16..32) sets the saturation width of the parsed numbers.
module imu_frame_status_line_parser
  import imu_fsl_pkg::*;
#(
  parameter int FIELD_BITS = 32
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_rx_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_record_kind,
  output logic [DATA_W-1:0]        out_stamp_nsec,
  output logic [DATA_W-1:0]        out_stamp_sec,
  output logic signed [DATA_W-1:0] out_accel_x,
  output logic signed [DATA_W-1:0] out_accel_y,
  output logic signed [DATA_W-1:0] out_accel_z,
  output logic signed [DATA_W-1:0] out_gyro_x,
  output logic signed [DATA_W-1:0] out_gyro_y,
  output logic signed [DATA_W-1:0] out_gyro_z
);

  byte_req_t req;
  line_t     line;
  logic      out_block;

  // input register
  imu_fsl_in u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .out_block  (out_block),
    .req        (req)
  );

  // line parser
  imu_fsl_parse #(
    .FIELD_BITS (FIELD_BITS)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .line  (line)
  );

  // record kind, watchdog and result register
  imu_fsl_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .line            (line),
    .out_block       (out_block),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_record_kind (out_record_kind),
    .out_stamp_nsec  (out_stamp_nsec),
    .out_stamp_sec   (out_stamp_sec),
    .out_accel_x     (out_accel_x),
    .out_accel_y     (out_accel_y),
    .out_accel_z     (out_accel_z),
    .out_gyro_x      (out_gyro_x),
    .out_gyro_y      (out_gyro_y),
    .out_gyro_z      (out_gyro_z)
  );

endmodule

### dv/imu_frame_status_line_parser_test.sv
// self-checking testbench for imu_frame_status_line_parser: byte driver, record monitor
// and a line-parser predictor kept in step with every accepted request
// depends on imu_fsl_pkg and the imu_frame_status_line_parser design
module imu_frame_status_line_parser_test;
  import imu_fsl_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int BYTE_TARGET = 1900;
  localparam int HOLD_START  = 1500;
  localparam int HOLD_LEN    = 400;
  localparam int DRAIN_WAIT  = 8;

  // parse positions inside a line
  localparam logic [3:0] POS_TYPE  = 4'd0;
  localparam logic [3:0] POS_COLON = 4'd1;
  localparam logic [3:0] POS_NUM0  = 4'd2;
  localparam logic [3:0] POS_DONE  = 4'd10;

  localparam logic [32:0] MAG_CAP = 33'h1_0000_0000;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] nsec;
    logic [31:0] sec;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] gz;
  } imu_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_record_kind;
  logic [31:0] out_stamp_nsec;
  logic [31:0] out_stamp_sec;
  logic signed [31:0] out_accel_x;
  logic signed [31:0] out_accel_y;
  logic signed [31:0] out_accel_z;
  logic signed [31:0] out_gyro_x;
  logic signed [31:0] out_gyro_y;
  logic signed [31:0] out_gyro_z;

  logic [7:0] rx_pending[$];
  imu_rec_t   rec_expected[$];
  int         bytes_total = 0;
  int         bytes_taken = 0;
  int         mismatches = 0;
  int         run_cycles = 0;

  // predictor state
  bit          synced;
  logic [3:0]  fpos;
  bit          line_bad;
  logic [32:0] mag;
  bit          minus;
  bit          have_digit;
  bit          have_sign;
  logic [7:0]  line_type;
  logic [31:0] field_val [8];
  logic [1:0]  wd_trips;

  imu_frame_status_line_parser dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_record_kind (out_record_kind),
    .out_stamp_nsec  (out_stamp_nsec),
    .out_stamp_sec   (out_stamp_sec),
    .out_accel_x     (out_accel_x),
    .out_accel_y     (out_accel_y),
    .out_accel_z     (out_accel_z),
    .out_gyro_x      (out_gyro_x),
    .out_gyro_y      (out_gyro_y),
    .out_gyro_z      (out_gyro_z)
  );

  // ---------------------------------------------------------------- predictor

  function automatic bit is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
  endfunction

  task automatic clear_value();
    mag = '0;
    minus = 1'b0;
    have_digit = 1'b0;
    have_sign = 1'b0;
  endtask

  task automatic clear_line_state();
    fpos = POS_TYPE;
    line_bad = 1'b0;
    line_type = '0;
    clear_value();
    foreach (field_val[i]) field_val[i] = '0;
  endtask

  task automatic reset_parser_model();
    synced = 1'b0;
    wd_trips = '0;
    clear_line_state();
  endtask

  // saturate the running magnitude into the current field and move on
  task automatic store_value();
    int          idx;
    logic [32:0] m;
    logic [31:0] v;
    idx = int'(fpos - POS_NUM0) & 7;
    m = mag;
    if (idx < 2) begin
      if (m > 33'h0_FFFF_FFFF) m = 33'h0_FFFF_FFFF;
      v = m[31:0];
      if (minus) v = 32'd0 - v;
    end else if (minus) begin
      if (m > 33'h0_8000_0000) m = 33'h0_8000_0000;
      v = 32'd0 - m[31:0];
    end else begin
      if (m > 33'h0_7FFF_FFFF) m = 33'h0_7FFF_FFFF;
      v = m[31:0];
    end
    field_val[idx] = v;
    fpos = fpos + 4'd1;
    clear_value();
  endtask

  // one byte while inside the number fields
  task automatic take_number_byte(logic [7:0] c);
    bit          done;
    logic [35:0] t;
    done = 1'b0;
    while (!done && fpos >= POS_NUM0 && fpos < POS_DONE) begin
      if (c >= CH_0 && c <= CH_9) begin
        t = {3'b000, mag} * 36'd10 + 36'(c - CH_0);
        mag = (t > 36'(MAG_CAP)) ? MAG_CAP : t[32:0];
        have_digit = 1'b1;
        done = 1'b1;
      end else if (!have_digit && !have_sign && is_blank(c)) begin
        done = 1'b1;
      end else if (!have_digit && !have_sign && (c == CH_PLUS || c == CH_MINUS)) begin
        have_sign = 1'b1;
        minus = (c == CH_MINUS);
        done = 1'b1;
      end else if (have_digit) begin
        // a run-on byte falls through and may start the next number
        store_value();
        if (c == CH_NUL) begin
          line_bad = 1'b1;
          done = 1'b1;
        end else if (is_blank(c)) begin
          done = 1'b1;
        end
      end else begin
        line_bad = 1'b1;
        done = 1'b1;
      end
    end
  endtask

  // advance the model by one accepted byte, queue the record a newline gives
  task automatic predict_rx_byte(logic [7:0] c);
    imu_rec_t rec;
    bit       emit;
    if (!synced) begin
      if (c == CH_NL) begin
        synced = 1'b1;
        clear_line_state();
      end
    end else if (c != CH_NL) begin
      if (!line_bad) begin
        if (fpos == POS_TYPE) begin
          if (c == CH_NUL) line_bad = 1'b1;
          else begin
            line_type = c;
            fpos = POS_COLON;
          end
        end else if (fpos == POS_COLON) begin
          if (c == CH_COLON) fpos = POS_NUM0;
          else line_bad = 1'b1;
        end else begin
          take_number_byte(c);
        end
      end
    end else begin
      if (!line_bad && have_digit && fpos >= POS_NUM0 && fpos < POS_DONE) store_value();
      rec = '0;
      rec.nsec = field_val[0];
      rec.sec = field_val[1];
      emit = 1'b1;
      case (line_type)
        CH_I: begin
          rec.kind = KIND_IMU;
          rec.ax = field_val[2];
          rec.ay = field_val[3];
          rec.az = field_val[4];
          rec.gx = field_val[5];
          rec.gy = field_val[6];
          rec.gz = field_val[7];
        end
        CH_E: begin
          rec.kind = KIND_EOF;
          wd_trips = '0;
        end
        CH_S: begin
          rec.kind = KIND_SKIP;
        end
        CH_W: begin
          if (wd_trips != 2'd3) wd_trips = wd_trips + 2'd1;
          rec.kind = (wd_trips > 2'd1) ? KIND_WD_ERR : KIND_WD_RST;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      if (emit) rec_expected.push_back(rec);
      clear_line_state();
    end
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  task automatic push_byte(logic [7:0] b);
    rx_pending.push_back(b);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) rx_pending.push_back(s[i]);
  endtask

  task automatic push_blank();
    case ($urandom_range(0, 7))
      4: push_byte(CH_TAB);
      5: push_byte(CH_CR);
      6: push_byte(CH_VT);
      7: push_byte(CH_FF);
      default: push_byte(CH_SPACE);
    endcase
    if ($urandom_range(0, 5) == 0) push_byte(CH_SPACE);
  endtask

  // decimal text with an optional sign, sized from tiny to far past saturation
  function automatic string num_text();
    int    sel;
    string s;
    string d;
    sel = $urandom_range(0, 3);
    s = "";
    if (sel == 2) s = "-";
    else if (sel == 3) s = "+";
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      d = $sformatf("%0d", $urandom_range(0, 999));
    end else if (sel == 6) begin
      d = $sformatf("%0d", $urandom);
    end else if (sel == 7) begin
      case ($urandom_range(0, 5))
        0: d = "2147483647";
        1: d = "2147483648";
        2: d = "2147483649";
        3: d = "4294967295";
        4: d = "4294967296";
        default: d = "4294967297";
      endcase
    end else if (sel == 8) begin
      d = "";
      repeat ($urandom_range(10, 16)) d = {d, $sformatf("%0d", $urandom_range(0, 9))};
    end else begin
      d = {"000", $sformatf("%0d", $urandom_range(0, 99))};
    end
    return {s, d};
  endfunction

  // one random line: mostly well formed, some broken, some short, some noise
  task automatic gen_line();
    int         r;
    int         k;
    int         nnum;
    int         start;
    logic [7:0] t;
    start = rx_pending.size();
    r = $urandom_range(0, 99);
    if (r < 70) begin
      k = $urandom_range(0, 9);
      t = (k < 5) ? CH_I : (k < 7) ? CH_W : (k < 9) ? CH_E : CH_S;
      push_byte(t);
      push_byte(CH_COLON);
      nnum = ($urandom_range(0, 3) != 0) ? 8 : $urandom_range(0, 10);
      for (k = 0; k < nnum; k++) begin
        if ((k > 0 && $urandom_range(0, 7) != 0) || $urandom_range(0, 3) == 0) push_blank();
        push_text(num_text());
      end
      if ($urandom_range(0, 4) == 0) push_blank();
      // broken: one stray byte dropped somewhere into the line
      if (r >= 55) begin
        k = $urandom_range(start, rx_pending.size() - 1);
        t = ($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(0, 255));
        rx_pending.insert(k, t);
      end
    end else if (r < 82) begin
      case ($urandom_range(0, 5))
        0: push_byte(CH_E);
        1: push_byte(CH_S);
        2: push_byte(CH_W);
        3: push_byte(CH_I);
        default: push_byte(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 1) == 0) push_byte(CH_COLON);
    end else if (r < 94) begin
      repeat ($urandom_range(0, 12)) push_byte(8'($urandom_range(0, 255)));
    end
    push_byte(CH_NL);
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------- clock and timeout

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    run_cycles <= run_cycles + 1;
    if (run_cycles >= RUN_LIMIT) begin
      $display("imu_frame_status_line_parser_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- byte driver

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= 8'h00;
      reset_parser_model();
    end else begin
      // request taken at this edge
      if (in_valid && !in_stall) begin
        predict_rx_byte(in_rx_byte);
        bytes_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_pending.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
              burst_left = $urandom_range(40, 160);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left = $urandom_range(1, 6);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver stall pattern

  int stall_cycles = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycles++;
      if (stall_cycles == HOLD_START) hold_left = HOLD_LEN;
      // long hold-off so the held newline backs up the input side
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- record monitor

  always @(posedge clk) begin : rec_monitor
    imu_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rec_expected.size() == 0) begin
        $error("record kind %0d arrived with none expected", out_record_kind);
        mismatches++;
      end else begin
        want = rec_expected.pop_front();
        check_field("record_kind", 32'(want.kind), 32'(out_record_kind));
        check_field("stamp_nsec", want.nsec, out_stamp_nsec);
        check_field("stamp_sec", want.sec, out_stamp_sec);
        check_field("accel_x", want.ax, out_accel_x);
        check_field("accel_y", want.ay, out_accel_y);
        check_field("accel_z", want.az, out_accel_z);
        check_field("gyro_x", want.gx, out_gyro_x);
        check_field("gyro_y", want.gy, out_gyro_y);
        check_field("gyro_z", want.gz, out_gyro_z);
      end
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin
    // bytes before the first newline, a zero byte among them, give nothing
    push_text("I:1 2 3 4 5 6 7 8");
    push_byte(CH_NUL);
    push_text("W:9\n");
    // empty line
    push_text("\n");
    // saturation at the top of the unsigned fields and at both ends of the signed ones
    push_text("I:4294967295 4294967296 2147483647 -2147483648 2147483648 -2147483649 ");
    push_text("99999999999 -99999999999\n");
    // minus on unsigned, explicit plus, leading zeros
    push_text("I:-5 +7 -0 +0 1 -1 00012 -00000000000000000003\n");
    push_text("E:11 22 33 44 55 66 77 88\n");
    push_text("S:3 4\n");
    // watchdog: restart, error, saturation, clear, restart again
    push_text("W:1 2\n");
    push_text("W\n");
    push_text("W:\n");
    push_text("W:0 0\n");
    push_text("E\n");
    push_text("W:5\n");
    // missing colon
    push_text("I 1 2 3\n");
    // malformed numbers
    push_text("I:1 2 x 4 5\n");
    push_text("I:1 - 3\n");
    push_text("I:+\n");
    push_text("I::5\n");
    push_text("I:1 2 3");
    push_byte(8'hB5);
    push_text(" 4\n");
    // run-on numbers
    push_text("I:12-5+3 7-8-9 10 11\n");
    // zero byte cuts a digit run, and a zero byte as the type
    push_text("I:12 34");
    push_byte(CH_NUL);
    push_text("56\n");
    push_byte(CH_NUL);
    push_text("E:1\n");
    // extra text after the eighth number
    push_text("I:1 2 3 4 5 6 7 8 9 10 junk\n");
    // every separator kind
    push_text("I:1");
    push_byte(CH_TAB);
    push_text("2");
    push_byte(CH_CR);
    push_text("3");
    push_byte(CH_VT);
    push_text("4");
    push_byte(CH_FF);
    push_text("5  6\t\t7 8 \n");
    // other types give nothing
    push_text("X:1 2 3\n");
    push_byte(8'hFF);
    push_text(":1\n");
    // short line after a long one sees no leftovers
    push_text("I:9\n");
    push_text("S\n");
    push_text("E:-1 -4294967296\n");

    while (rx_pending.size() < BYTE_TARGET) gen_line();
    bytes_total = rx_pending.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < bytes_total) @(posedge clk);
    while (rec_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("imu_frame_status_line_parser_test passed");
    end else begin
      $display("imu_frame_status_line_parser_test failed");
    end
    $finish;
  end

endmodule
